// File: design/plid_pkg.sv
package plid_pkg;

  // list size and derived widths
  localparam int CAPACITY = 64;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 7;
  localparam int LEN_W    = 7;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  // stream word layout
  localparam int IN_W     = ((POS_W + VAL_W + 7) / 8) * 8;
  localparam int IN_PAD   = IN_W - POS_W - VAL_W;
  localparam int OUT_BITS = STAT_W + VAL_W + LEN_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD  = OUT_W - OUT_BITS;

  // pick tree: 4-input or nodes, one register per level
  localparam int TREE_LEVELS = ($clog2(CAPACITY) + 1) / 2;
  localparam int TREE_LEAVES = 4 ** TREE_LEVELS;
  localparam int WAIT_W      = $clog2(TREE_LEVELS + 1);

  localparam logic [VAL_W-1:0] REMOVED_FAIL = {VAL_W{1'b1}};

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_OUT
  } state_t;

  // per-cell command for one cycle
  typedef struct packed {
    logic load_new;
    logic from_left;
    logic from_right;
    logic pick;
  } cell_ctl_t;

endpackage

// File: design/plid_cell.sv
module plid_cell (
  input  logic                       clk,
  input  plid_pkg::cell_ctl_t        ctl,
  input  logic [plid_pkg::VAL_W-1:0] new_value,
  input  logic [plid_pkg::VAL_W-1:0] left,
  input  logic [plid_pkg::VAL_W-1:0] right,
  output logic [plid_pkg::VAL_W-1:0] value,
  output logic [plid_pkg::VAL_W-1:0] pick
);
  import plid_pkg::*;

  // one list slot; shifts toward either neighbor
  always_ff @(posedge clk) begin
    if (ctl.load_new) begin
      value <= new_value;
    end else if (ctl.from_left) begin
      value <= left;
    end else if (ctl.from_right) begin
      value <= right;
    end
    pick <= ctl.pick ? value : '0;
  end

endmodule

// File: design/plid_pick_tree.sv
module plid_pick_tree (
  input  logic                       clk,
  input  logic [plid_pkg::VAL_W-1:0] leaf [plid_pkg::CAPACITY],
  output logic [plid_pkg::VAL_W-1:0] root
);
  import plid_pkg::*;

  localparam int ROW_W = TREE_LEAVES * VAL_W;

  logic [ROW_W-1:0] lvl [TREE_LEVELS+1];

  function automatic logic [ROW_W-1:0] fold4(input logic [ROW_W-1:0] v);
    logic [ROW_W-1:0] r;
    r = '0;
    for (int j = 0; j < TREE_LEAVES / 4; j++) begin
      r[j*VAL_W +: VAL_W] = v[(4*j)*VAL_W +: VAL_W] | v[(4*j+1)*VAL_W +: VAL_W]
                          | v[(4*j+2)*VAL_W +: VAL_W] | v[(4*j+3)*VAL_W +: VAL_W];
    end
    return r;
  endfunction

  always_comb begin
    lvl[0] = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      lvl[0][i*VAL_W +: VAL_W] = leaf[i];
    end
  end

  for (genvar l = 1; l <= TREE_LEVELS; l++) begin : g_level
    always_ff @(posedge clk) begin
      lvl[l] <= fold4(lvl[l-1]);
    end
  end

  assign root = lvl[TREE_LEVELS][VAL_W-1:0];

endmodule

// File: design/positional_list_insert_delete.sv
// channel | dir | handshake              | payload
// s       | in  | s_tvalid / s_tready    | s_tuser: req_type; s_tdata: position, new_value
// m       | out | m_tvalid / m_tready    | m_tdata: status, removed_value, list_length
//
// one request at a time; a new word is accepted only after the result of the
// last one is taken; the registered 4-input or tree pulls the deleted value
// out of the cell row
// the list shifts in the accept cycle itself; only the removed value waits
// rst is synchronous and active high; it empties the list and the fsm,
// the cell contents stay undefined until written
// a stalled result holds m_tdata; s_tready stays low until it is taken
module positional_list_insert_delete (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [plid_pkg::IN_W-1:0]     s_tdata,   // position, new_value, zero pad
  input  logic                          s_tuser,   // req_type
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [plid_pkg::OUT_W-1:0]    m_tdata    // status, removed_value, list_length, zero pad
);
  import plid_pkg::*;

  // request fields
  logic              req_delete;
  logic [POS_W-1:0]  position;
  logic [VAL_W-1:0]  new_value;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  count_ext;

  // list length and fsm
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  state_t            state;
  state_t            state_next;
  logic [WAIT_W-1:0] wait_cnt;

  // request decode
  logic accept;
  logic ins_range_bad;
  logic ins_full;
  logic ins_ok;
  logic del_bad;
  logic del_ok;
  logic capture;

  // held result
  status_t           res_status;
  logic [LEN_W-1:0]  res_len;
  logic [VAL_W-1:0]  res_value;
  logic              res_del_ok;
  logic              res_del_bad;

  // cell row
  cell_ctl_t         ctl      [CAPACITY];
  logic [VAL_W-1:0]  cell_val [CAPACITY];
  logic [VAL_W-1:0]  cell_pick[CAPACITY];
  logic [CAPACITY-1:0] pick_vec;
  logic [VAL_W-1:0]  root;

  assign req_delete = s_tuser;
  assign position   = s_tdata[POS_W-1:0];
  assign new_value  = s_tdata[POS_W +: VAL_W];
  assign pos_ext    = CMP_W'(position);
  assign count_ext  = CMP_W'(count);

  assign accept        = s_tvalid && s_tready;
  assign ins_range_bad = pos_ext > count_ext;
  assign ins_full      = count == CNT_W'(CAPACITY);
  assign ins_ok        = accept && !req_delete && !ins_range_bad && !ins_full;
  assign del_bad       = (position == '0) || ins_range_bad;
  assign del_ok        = accept && req_delete && !del_bad;

  // per-cell commands: insert shifts up past the slot, delete shifts down from it
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctl[i].load_new   = ins_ok && (CMP_W'(i) == pos_ext);
      ctl[i].from_left  = ins_ok && (CMP_W'(i) > pos_ext);
      ctl[i].from_right = del_ok && (CMP_W'(i + 1) >= pos_ext);
      ctl[i].pick       = del_ok && (CMP_W'(i + 1) == pos_ext);
      pick_vec[i]       = ctl[i].pick;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] left_val;
    logic [VAL_W-1:0] right_val;
    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end
    plid_cell u_cell (
      .clk       (clk),
      .ctl       (ctl[i]),
      .new_value (new_value),
      .left      (left_val),
      .right     (right_val),
      .value     (cell_val[i]),
      .pick      (cell_pick[i])
    );
  end

  // deleted value reaches root through the registered tree levels after the pick registers load
  plid_pick_tree u_tree (
    .clk  (clk),
    .leaf (cell_pick),
    .root (root)
  );

  // length update
  always_comb begin
    count_next = count;
    if (ins_ok) begin
      count_next = count + CNT_W'(1);
    end else if (del_ok) begin
      count_next = count - CNT_W'(1);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_WAIT;
      end
      S_WAIT: begin
        if (wait_cnt == '0) state_next = S_OUT;
      end
      S_OUT: begin
        if (m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    capture  = 1'b0;
    case (state)
      S_IDLE:  s_tready = 1'b1;
      S_WAIT:  capture  = wait_cnt == '0;
      S_OUT:   m_tvalid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      wait_cnt <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (accept) begin
        wait_cnt <= WAIT_W'(TREE_LEVELS);
      end else if (state == S_WAIT && wait_cnt != '0) begin
        wait_cnt <= wait_cnt - WAIT_W'(1);
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      res_len     <= LEN_W'(count_next);
      res_del_ok  <= req_delete && !del_bad;
      res_del_bad <= req_delete && del_bad;
      if (req_delete) begin
        res_status <= del_bad ? ST_RANGE : ST_DONE;
      end else if (ins_range_bad) begin
        res_status <= ST_RANGE;
      end else if (ins_full) begin
        res_status <= ST_FULL;
      end else begin
        res_status <= ST_DONE;
      end
    end
    if (capture) begin
      if (res_del_ok) begin
        res_value <= root;
      end else if (res_del_bad) begin
        res_value <= REMOVED_FAIL;
      end else begin
        res_value <= '0;
      end
    end
  end

  assign m_tdata = {{OUT_PAD{1'b0}}, res_len, res_value, res_status};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("list length above capacity");

  a_one_pick: assert property (@(posedge clk) disable iff (rst)
    $onehot0(pick_vec))
    else $error("more than one cell picked");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ins_ok |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (rst)
    del_ok |=> count == $past(count) - CNT_W'(1))
    else $error("delete did not shrink the list");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("request taken while a result is pending");
`endif

endmodule
